// ===== hdl/lfdt_pkg.sv =====
// Shared types and constants for the lowest free descriptor table.
`default_nettype none
package lfdt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int HANDLE_W    = 32;
    localparam int DESC_IN_W   = 8;
    localparam int DESC_OUT_W  = 7;

    localparam logic [DESC_OUT_W-1:0] DESC_NONE = {DESC_OUT_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_REGISTER   = 2'd0,
        ACT_UNREGISTER = 2'd1,
        ACT_LOOKUP     = 2'd2,
        ACT_FIND       = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    // Query travelling down the row of cells, one cell per cycle.
    typedef struct packed {
        logic                valid;
        action_t             action;
        logic                hnz;
        logic [HANDLE_W-1:0] handle;
        logic                desc_ok;
        logic [IDX_W-1:0]    desc_idx;
        logic                found;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] hval;
    } query_t;

    // Append write broadcast to all cells.
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] data;
    } append_t;

endpackage
`default_nettype wire

// ===== hdl/lfdt_cell.sv =====
// One table slot and one stage of the query chain.
`default_nettype none
module lfdt_cell
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lfdt_pkg::IDX_W-1:0] cell_idx,
    input  wire logic [lfdt_pkg::LEN_W-1:0] used_len,
    input  wire lfdt_pkg::append_t          app,
    input  wire lfdt_pkg::query_t           q_in,
    output lfdt_pkg::query_t                q_out
);

    logic [lfdt_pkg::HANDLE_W-1:0] slot_reg;
    logic [lfdt_pkg::HANDLE_W-1:0] slot_next;
    lfdt_pkg::query_t              q_reg;
    lfdt_pkg::query_t              q_next;
    logic                          in_use;
    logic                          slot_empty;

    assign in_use     = {1'b0, cell_idx} < used_len;
    assign slot_empty = slot_reg == '0;

    always_comb
    begin
        q_next    = q_in;
        slot_next = slot_reg;
        if (q_in.valid && !q_in.found)
        begin
            unique case (q_in.action)
                lfdt_pkg::ACT_REGISTER:
                begin
                    if (q_in.hnz && in_use && slot_empty)
                    begin
                        slot_next    = q_in.handle;
                        q_next.found = 1'b1;
                        q_next.idx   = cell_idx;
                    end
                end
                lfdt_pkg::ACT_FIND:
                begin
                    if (q_in.hnz && in_use && slot_reg == q_in.handle)
                    begin
                        q_next.found = 1'b1;
                        q_next.idx   = cell_idx;
                    end
                end
                lfdt_pkg::ACT_UNREGISTER, lfdt_pkg::ACT_LOOKUP:
                begin
                    if (q_in.desc_ok && q_in.desc_idx == cell_idx && !slot_empty)
                    begin
                        q_next.found = 1'b1;
                        q_next.idx   = cell_idx;
                        q_next.hval  = slot_reg;
                        if (q_in.action == lfdt_pkg::ACT_UNREGISTER)
                        begin
                            slot_next = '0;
                        end
                    end
                end
                default:
                begin
                    q_next = q_in;
                end
            endcase
        end
        if (app.en && app.idx == cell_idx)
        begin
            slot_next = app.data;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule
`default_nettype wire

// ===== hdl/lowest_free_descriptor_table_unit.sv =====
// Top level: lowest free descriptor table built as a row of slot cells.
// Flow: the accepting edge loads the first cell, the query walks the row of cells
// and then moves into the result hold and on into the output register, which
// presents the result beat. One command at a time: none is taken during the walk,
// and busy drops as the result enters the output register. A held result adds
// its stall.
// Reset: rst_n clears used length, busy flag and the valid bits of all beats;
// slot contents are not cleared and are only read once written.
`default_nettype none
module lowest_free_descriptor_table_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [7:0] descriptor, [39:8] handle
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [6:0] descriptor_out, [38:7] handle_out
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int Depth = lfdt_pkg::TABLE_DEPTH;

    // control
    logic                         busy_reg, busy_next;
    logic [lfdt_pkg::LEN_W-1:0]   used_reg, used_next;

    // result hold (one beat waiting for the output register)
    logic                         pend_valid_reg, pend_valid_next;
    lfdt_pkg::status_t            pend_status_reg, pend_status_next;
    logic [lfdt_pkg::DESC_OUT_W-1:0] pend_desc_reg, pend_desc_next;
    logic [lfdt_pkg::HANDLE_W-1:0]   pend_handle_reg, pend_handle_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    lfdt_pkg::status_t            out_status_reg, out_status_next;
    logic [lfdt_pkg::DESC_OUT_W-1:0] out_desc_reg, out_desc_next;
    logic [lfdt_pkg::HANDLE_W-1:0]   out_handle_reg, out_handle_next;

    logic                         in_beat;
    logic                         out_free;
    logic                         pend_move;
    logic [lfdt_pkg::DESC_IN_W-1:0] desc_in;
    lfdt_pkg::query_t             head;
    lfdt_pkg::query_t             chain [Depth+1];
    lfdt_pkg::query_t             tail;
    lfdt_pkg::append_t            app;

    assign s_axis_tready = !busy_reg;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pend_move     = pend_valid_reg && out_free;

    // Query entering the head of the row on an accepted beat.
    assign desc_in = s_axis_tdata[7:0];
    always_comb
    begin
        head          = '0;
        head.valid    = in_beat;
        head.action   = lfdt_pkg::action_t'(s_axis_tuser);
        head.handle   = s_axis_tdata[39:8];
        head.hnz      = s_axis_tdata[39:8] != '0;
        // negative or beyond the used length: rejected by every cell
        head.desc_ok  = !desc_in[7] && (desc_in[6:0] < used_reg);
        head.desc_idx = desc_in[lfdt_pkg::IDX_W-1:0];
    end

    assign chain[0] = head;

    genvar gi;
    generate
        for (gi = 0; gi < Depth; gi++)
        begin : g_cell
            lfdt_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (lfdt_pkg::IDX_W'(gi)),
                .used_len (used_reg),
                .app      (app),
                .q_in     (chain[gi]),
                .q_out    (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[Depth];

    // Wrap-up once the query leaves the last cell: append on a register miss with a
    // nonzero handle while the table has room, and form the result beat.
    always_comb
    begin
        app              = '0;
        used_next        = used_reg;
        pend_status_next = pend_status_reg;
        pend_desc_next   = pend_desc_reg;
        pend_handle_next = pend_handle_reg;
        if (tail.valid)
        begin
            if (tail.found)
            begin
                pend_status_next = lfdt_pkg::ST_OK;
                pend_desc_next   = lfdt_pkg::DESC_OUT_W'(tail.idx);
                pend_handle_next = tail.hval;
            end
            else if (tail.action == lfdt_pkg::ACT_REGISTER && tail.hnz
                     && used_reg < lfdt_pkg::LEN_W'(Depth))
            begin
                app.en           = 1'b1;
                app.idx          = used_reg[lfdt_pkg::IDX_W-1:0];
                app.data         = tail.handle;
                used_next        = used_reg + 1'b1;
                pend_status_next = lfdt_pkg::ST_OK;
                pend_desc_next   = lfdt_pkg::DESC_OUT_W'(used_reg);
                pend_handle_next = '0;
            end
            else if (tail.action == lfdt_pkg::ACT_REGISTER && tail.hnz)
            begin
                pend_status_next = lfdt_pkg::ST_FULL;
                pend_desc_next   = lfdt_pkg::DESC_NONE;
                pend_handle_next = '0;
            end
            else
            begin
                pend_status_next = lfdt_pkg::ST_BAD;
                pend_desc_next   = lfdt_pkg::DESC_NONE;
                pend_handle_next = '0;
            end
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        busy_next       = busy_reg;
        if (in_beat)
        begin
            busy_next = 1'b1;
        end
        if (pend_move)
        begin
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
        if (tail.valid)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_desc_next   = out_desc_reg;
        out_handle_next = out_handle_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_move)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_desc_next   = pend_desc_reg;
            out_handle_next = pend_handle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_desc_reg   <= pend_desc_next;
        pend_handle_reg <= pend_handle_next;
        out_status_reg  <= out_status_next;
        out_desc_reg    <= out_desc_next;
        out_handle_reg  <= out_handle_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_handle_reg, out_desc_reg};

    // used length never passes the table depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= lfdt_pkg::LEN_W'(Depth))
        else $error("used length beyond table depth");

    // a query leaving the row belongs to an accepted command
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> busy_reg && !pend_valid_reg)
        else $error("query left row while idle or hold full");

    // table full only reported with the table at full length
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && pend_status_reg == lfdt_pkg::ST_FULL)
        |-> used_reg == lfdt_pkg::LEN_W'(Depth))
        else $error("table full with free length");

    // an accepted beat locks out the next until its result is handed on
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("second command taken while busy");

endmodule
`default_nettype wire
